// File: src/cpp_pkg.sv
// Shared constants and types for the capsule point pushout block.
// Used by the top level and by the pipelined divider.
`timescale 1ns / 1ps

package cpp_pkg;

  localparam int LANES = 3;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_CENTER_Z     = 3'd2,
    CFG_RADIUS_X     = 3'd3,
    CFG_RADIUS_Y     = 3'd4,
    CFG_RADIUS_Z     = 3'd5,
    CFG_TOTAL_HEIGHT = 3'd6
  } cfg_reg_t;

endpackage

// File: src/cpp_divpipe.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes wide.
// Depends on cpp_pkg; a sideband tag travels with each item.
`timescale 1ns / 1ps

module cpp_divpipe import cpp_pkg::*; #(
  parameter int DW = 31,
  parameter int NB = 16,
  parameter int TW = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [LANES-1:0][DW-1:0]   in_rem,
  input  logic [LANES-1:0][DW-1:0]   in_div,
  input  logic [LANES-1:0][NB-1:0]   in_bits,
  input  logic [TW-1:0]              in_tag,
  output logic                       out_vld,
  output logic [LANES-1:0][NB-1:0]   out_quo,
  output logic [TW-1:0]              out_tag
);

  logic                     vld [0:NB];
  logic [LANES-1:0][DW-1:0] rem [0:NB];
  logic [LANES-1:0][DW-1:0] dv  [0:NB];
  logic [LANES-1:0][NB-1:0] bts [0:NB];
  logic [LANES-1:0][NB-1:0] quo [0:NB];
  logic [TW-1:0]            tag [0:NB];

  assign vld[0] = in_vld;
  assign rem[0] = in_rem;
  assign dv[0]  = in_div;
  assign bts[0] = in_bits;
  assign quo[0] = '0;
  assign tag[0] = in_tag;

  genvar k;
  generate
    for (k = 0; k < NB; k++) begin : g_stage
      logic [LANES-1:0][DW-1:0] rem_next;
      logic [LANES-1:0][NB-1:0] quo_next;
      logic [LANES-1:0][NB-1:0] bts_next;

      always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int l = 0; l < LANES; l++) begin
          t = {rem[k][l], bts[k][l][NB-1]};
          ge = (t >= {1'b0, dv[k][l]});
          rem_next[l] = ge ? DW'(t - {1'b0, dv[k][l]}) : t[DW-1:0];
          quo_next[l] = NB'({quo[k][l], ge});
          bts_next[l] = NB'({bts[k][l], 1'b0});
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (en) begin
          vld[k+1] <= vld[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= rem_next;
          quo[k+1] <= quo_next;
          bts[k+1] <= bts_next;
          dv[k+1]  <= dv[k];
          tag[k+1] <= tag[k];
        end
      end
    end
  endgenerate

  assign out_vld = vld[NB];
  assign out_quo = quo[NB];
  assign out_tag = tag[NB];

endmodule

// File: src/capsule_point_pushout.sv
// Coordinates are fixed point with FRAC_BITS fraction bits (Q16.16 by default).
// Accepts one vertex per cycle; the whole pipeline holds while the output stalls.
// Depth is set by two bit-serial dividers and the square root, one bit per stage each.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
// Depends on cpp_pkg and cpp_divpipe.
`timescale 1ns / 1ps

module capsule_point_pushout import cpp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // vertex_x, vertex_y, vertex_z, zero pad
  input  logic [((LANES*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_x, out_y, out_z, zero pad
  output logic [((LANES*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // hit
  output logic                                 m_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW  = CW - 1;
  localparam int YW  = CW + 2;
  localparam int DFW = CW + 3;
  localparam int BW  = ((LANES * CW + 7) / 8) * 8;
  localparam int PW  = RW + F + 1;

  localparam logic signed [YW:0] SMAX = {{(YW-CW+2){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [YW:0] SMIN = {{(YW-CW+2){1'b1}}, {(CW-1){1'b0}}};

  typedef struct packed {
    logic                     flag;
    logic [LANES-1:0]         sg;
    logic [LANES-1:0][CW-1:0] v;
    logic signed [YW-1:0]     cy;
  } side_t;

  localparam int SW = $bits(side_t);

  // Configuration registers.
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic [RW-1:0] radius_x, radius_y, radius_z, total_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      center_z     <= '0;
      radius_x     <= RW'(1) << F;
      radius_y     <= RW'(1) << F;
      radius_z     <= RW'(1) << F;
      total_height <= RW'(1) << F;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X:     center_x <= cfg_data;
        CFG_CENTER_Y:     center_y <= cfg_data;
        CFG_CENTER_Z:     center_z <= cfg_data;
        CFG_RADIUS_X:     radius_x <= cfg_data[RW-1:0];
        CFG_RADIUS_Y:     radius_y <= cfg_data[RW-1:0];
        CFG_RADIUS_Z:     radius_z <= cfg_data[RW-1:0];
        CFG_TOTAL_HEIGHT: total_height <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  logic [LANES-1:0][RW-1:0] radius;
  assign radius = {radius_z, radius_y, radius_x};

  // Plane and clamp limits derived from configuration.
  logic signed [YW-1:0] lim_top, lim_bot, lim_lo, lim_hi;
  logic signed [YW-1:0] ycen, half_w, ry_w, top_w, bot_w;

  assign ycen   = YW'(center_y);
  assign half_w = $signed(YW'(total_height >> 1));
  assign ry_w   = $signed(YW'(radius_y));
  assign top_w  = ycen + half_w;
  assign bot_w  = ycen - half_w;

  always_ff @(posedge clk) begin
    lim_top <= top_w;
    lim_bot <= bot_w;
    lim_lo  <= bot_w + ry_w;
    lim_hi  <= top_w - ry_w;
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 0: input register.
  logic vld0;
  logic [LANES-1:0][CW-1:0] v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0 <= s_tdata[LANES*CW-1:0];
    end
  end

  // Stage 1: end plane test and axis clamp.
  logic vld1, inr1;
  logic [LANES-1:0][CW-1:0] v1;
  logic signed [YW-1:0] cy1;
  logic signed [YW-1:0] vy_w, cy_lo;

  assign vy_w  = YW'($signed(v0[1]));
  assign cy_lo = (vy_w < lim_lo) ? lim_lo : vy_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr1 <= (vy_w > lim_bot) && (vy_w < lim_top);
      cy1  <= (cy_lo > lim_hi) ? lim_hi : cy_lo;
      v1   <= v0;
    end
  end

  // Stage 2: offsets from the sphere centre.
  logic vld2, inr2;
  logic [LANES-1:0][CW-1:0] v2;
  logic signed [YW-1:0] cy2;
  logic signed [DFW-1:0] d2 [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2[0] <= DFW'($signed(v1[0])) - DFW'(center_x);
      d2[1] <= DFW'($signed(v1[1])) - DFW'(cy1);
      d2[2] <= DFW'($signed(v1[2])) - DFW'(center_z);
      inr2  <= inr1;
      cy2   <= cy1;
      v2    <= v1;
    end
  end

  // Stage 3: magnitudes and the box test against the radii.
  logic vld3;
  side_t side3;
  logic [LANES-1:0][RW-1:0] mag3;
  logic [LANES-1:0][DFW-1:0] mag_w;
  logic [LANES-1:0] ins_w, sg_w;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sg_w[l]  = d2[l][DFW-1];
      mag_w[l] = sg_w[l] ? DFW'(-d2[l]) : DFW'(d2[l]);
      ins_w[l] = mag_w[l] < DFW'(radius[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3.flag <= inr2 && (&ins_w);
      side3.sg   <= sg_w;
      side3.v    <= v2;
      side3.cy   <= cy2;
      for (int l = 0; l < LANES; l++) begin
        mag3[l] <= mag_w[l][RW-1:0];
      end
    end
  end

  // Scale into unit-radius space.
  logic vld_d1;
  logic [LANES-1:0][F-1:0] u_d1;
  logic [SW-1:0] tag_d1;

  cpp_divpipe #(.DW(RW), .NB(F), .TW(SW)) u_unit_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (vld3),
    .in_rem  (mag3),
    .in_div  (radius),
    .in_bits ('0),
    .in_tag  (SW'(side3)),
    .out_vld (vld_d1),
    .out_quo (u_d1),
    .out_tag (tag_d1)
  );

  // Stage 4: squares.
  logic vld4;
  side_t side4;
  logic [LANES-1:0][F-1:0] u4;
  logic [LANES-1:0][2*F-1:0] sq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (en) begin
      vld4 <= vld_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        sq4[l] <= u_d1[l] * u_d1[l];
      end
      u4    <= u_d1;
      side4 <= side_t'(tag_d1);
    end
  end

  // Stage 5 and square root chain.
  logic [2*F+1:0] ssum;
  assign ssum = (2*F+2)'(sq4[0]) + (2*F+2)'(sq4[1]) + (2*F+2)'(sq4[2]);

  side_t side_sq;

  always_comb begin
    side_sq      = side4;
    side_sq.flag = side4.flag && (ssum != '0) && (ssum[2*F+1:2*F] == 2'b00);
  end

  logic                    q_vld  [0:F];
  logic [F+1:0]            q_rem  [0:F];
  logic [F-1:0]            q_root [0:F];
  logic [2*F-1:0]          q_s    [0:F];
  logic [LANES-1:0][F-1:0] q_u    [0:F];
  side_t                   q_side [0:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld[0] <= 1'b0;
    end else if (en) begin
      q_vld[0] <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_rem[0]  <= '0;
      q_root[0] <= '0;
      q_s[0]    <= ssum[2*F-1:0];
      q_u[0]    <= u4;
      q_side[0] <= side_sq;
    end
  end

  genvar k;
  generate
    for (k = 0; k < F; k++) begin : g_sqrt
      logic [F+3:0] t, trial;
      logic         ge;

      assign t     = {q_rem[k], q_s[k][2*F-1:2*F-2]};
      assign trial = (F+4)'({q_root[k], 2'b01});
      assign ge    = (t >= trial);

      always_ff @(posedge clk) begin
        if (rst) begin
          q_vld[k+1] <= 1'b0;
        end else if (en) begin
          q_vld[k+1] <= q_vld[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          q_rem[k+1]  <= ge ? (F+2)'(t - trial) : (F+2)'(t);
          q_root[k+1] <= F'({q_root[k], ge});
          q_s[k+1]    <= (2*F)'({q_s[k], 2'b00});
          q_u[k+1]    <= q_u[k];
          q_side[k+1] <= q_side[k];
        end
      end
    end
  endgenerate

  // Normalize onto the unit sphere.
  logic [LANES-1:0][F-1:0] nrem, nlen;
  logic [LANES-1:0][F:0]   nbits;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nrem[l]  = q_u[F][l] >> 1;
      nlen[l]  = q_root[F];
      nbits[l] = (F+1)'({q_u[F][l][0], F'(0)});
    end
  end

  logic vld_d2;
  logic [LANES-1:0][F:0] n_d2;
  logic [SW-1:0] tag_d2;
  side_t side_d2;
  assign side_d2 = side_t'(tag_d2);

  cpp_divpipe #(.DW(F), .NB(F+1), .TW(SW)) u_norm_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (q_vld[F]),
    .in_rem  (nrem),
    .in_div  (nlen),
    .in_bits (nbits),
    .in_tag  (SW'(q_side[F])),
    .out_vld (vld_d2),
    .out_quo (n_d2),
    .out_tag (tag_d2)
  );

  // Stage 6: scale back by the radii.
  logic vld6;
  side_t side6;
  logic [LANES-1:0][PW-1:0] prod6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else if (en) begin
      vld6 <= vld_d2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        prod6[l] <= PW'(radius[l]) * PW'(n_d2[l]);
      end
      side6 <= side_d2;
    end
  end

  // Output register: offset from the centre, saturate, or pass the vertex.
  logic signed [YW:0] cen_w [LANES];
  logic [LANES-1:0][CW-1:0] res_w;

  assign cen_w[0] = (YW+1)'(center_x);
  assign cen_w[1] = (YW+1)'(side6.cy);
  assign cen_w[2] = (YW+1)'(center_z);

  always_comb begin
    logic signed [YW:0] m, sum;
    for (int l = 0; l < LANES; l++) begin
      m   = $signed((YW+1)'(prod6[l][RW+F-1:F]));
      sum = side6.sg[l] ? cen_w[l] - m : cen_w[l] + m;
      if (!side6.flag) begin
        res_w[l] = side6.v[l];
      end else if (sum > SMAX) begin
        res_w[l] = SMAX[CW-1:0];
      end else if (sum < SMIN) begin
        res_w[l] = SMIN[CW-1:0];
      end else begin
        res_w[l] = sum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= BW'(res_w);
      m_tuser <= side6.flag;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    q_vld[F] && q_side[F].flag |-> q_root[F] != '0)
    else $error("zero length on a hit");

  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    vld_d2 && side_d2.flag |->
      n_d2[0] <= ((F+1)'(1) << F) && n_d2[1] <= ((F+1)'(1) << F) &&
      n_d2[2] <= ((F+1)'(1) << F))
    else $error("normalized component above one");

endmodule
